### hdl/dts_pkg.sv
// Shared widths, register codes and pipeline types for the driveline torque split.
package dts_pkg;

  localparam int unsigned WORD_W = 32;             // field width, signed Q16.16
  localparam int unsigned Q_W    = 32;             // quotient bits, one per divider stage
  localparam int unsigned DEN_W  = 30;             // divisor 2^24 + bias, bias < 2^29
  localparam int unsigned NUM_W  = Q_W + DEN_W;    // |torque| * bias
  localparam int unsigned BIAS_W = 29;             // bias ratio scaled by 2^24
  localparam int unsigned CFG_W  = 17;             // widest register
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_CONNECTED      = 2'd0,
    REG_FRONT_FRACTION = 2'd1,
    REG_FRONT_MAX_BIAS = 2'd2,
    REG_REAR_MAX_BIAS  = 2'd3
  } cfg_reg_t;

  // Per-request data that rides alongside the two dividers.
  typedef struct packed {
    logic                     conn;
    logic signed [WORD_W-1:0] front_t;
    logic signed [WORD_W-1:0] rear_t;
    logic                     front_neg;
    logic                     rear_neg;
    logic                     front_slow_left;
    logic                     rear_slow_left;
    logic signed [WORD_W-1:0] speed;
  } side_t;

endpackage

### hdl/driveline_torque_split.sv
// Top level: four-wheel torque split with a speed-sensing limited-slip bias per axle.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  request  | start / busy       | shaft_torque, four wheel speeds (Q16.16)
//  result   | done (one cycle)   | four spindle torques, driveshaft_speed
//  config   | cfg_write          | cfg_index, cfg_data
//
// One request is taken every cycle; busy is high only during reset.
// A request passes three arithmetic stages, the Q_W-stage
// bit-per-cycle divider of each axle, and the output register.
// Reset (rst, synchronous) restores the register defaults, clears the held
// speed and drops every request in flight. The receiver cannot stall, so
// the pipeline always advances and each result shows for one cycle on done.
module driveline_torque_split (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [dts_pkg::WORD_W-1:0] shaft_torque,
  input  logic signed [dts_pkg::WORD_W-1:0] front_left_speed,
  input  logic signed [dts_pkg::WORD_W-1:0] front_right_speed,
  input  logic signed [dts_pkg::WORD_W-1:0] rear_left_speed,
  input  logic signed [dts_pkg::WORD_W-1:0] rear_right_speed,
  input  logic                              cfg_write,
  input  logic [dts_pkg::IDX_W-1:0]         cfg_index,
  input  logic [dts_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic signed [dts_pkg::WORD_W-1:0] front_left_torque,
  output logic signed [dts_pkg::WORD_W-1:0] front_right_torque,
  output logic signed [dts_pkg::WORD_W-1:0] rear_left_torque,
  output logic signed [dts_pkg::WORD_W-1:0] rear_right_torque,
  output logic signed [dts_pkg::WORD_W-1:0] driveshaft_speed
);
  import dts_pkg::*;

  // Clamp a wide signed value to signed 32 bits.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [51:0] v);
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[WORD_W-1:0];
    end
  endfunction

  // Bias ratio scaled by 2^24: one below a quarter rad/s, ramp to a half, then max.
  function automatic logic [BIAS_W-1:0] bias(input logic [12:0] mb, input logic [32:0] d);
    logic signed [34:0] ms;
    logic signed [34:0] mr;
    logic signed [34:0] d4;
    logic signed [34:0] acc;
    ms  = 35'($signed({2'b00, mb})) - 35'sd256;
    mr  = 35'sd512 - 35'($signed({2'b00, mb}));
    d4  = $signed({17'd0, d[15:0], 2'b00});
    acc = ms * d4 + mr * 35'sd65536;
    if (d > 33'd32768) begin
      bias = {mb, 16'd0};
    end else if (d > 33'd16384) begin
      bias = acc[BIAS_W-1:0];
    end else begin
      bias = BIAS_W'(1 << 24);
    end
  endfunction

  // Configuration registers.
  logic        connected;
  logic [16:0] front_fraction;
  logic [12:0] front_max_bias;
  logic [12:0] rear_max_bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      connected      <= 1'b1;
      front_fraction <= 17'd32768;
      front_max_bias <= 13'd512;
      rear_max_bias  <= 13'd512;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONNECTED:      connected      <= cfg_data[0];
        REG_FRONT_FRACTION: front_fraction <= cfg_data;
        REG_FRONT_MAX_BIAS: front_max_bias <= cfg_data[12:0];
        REG_REAR_MAX_BIAS:  rear_max_bias  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  wire accept = start & ~busy;

  // Stage 1: products, speed differences, slower-wheel picks.
  logic signed [17:0] ff_s;
  logic signed [17:0] fr_w;
  logic signed [32:0] sum_f;
  logic signed [32:0] sum_r;
  logic signed [32:0] abs_fl, abs_fr, abs_rl, abs_rr, dif_f, dif_r;

  always_comb begin
    ff_s   = $signed({1'b0, front_fraction});
    fr_w   = 18'sd65536 - ff_s;
    sum_f  = 33'(front_left_speed) + 33'(front_right_speed);
    sum_r  = 33'(rear_left_speed) + 33'(rear_right_speed);
    abs_fl = front_left_speed < 0 ? -33'(front_left_speed) : 33'(front_left_speed);
    abs_fr = front_right_speed < 0 ? -33'(front_right_speed) : 33'(front_right_speed);
    abs_rl = rear_left_speed < 0 ? -33'(rear_left_speed) : 33'(rear_left_speed);
    abs_rr = rear_right_speed < 0 ? -33'(rear_right_speed) : 33'(rear_right_speed);
    dif_f  = 33'(front_left_speed) - 33'(front_right_speed);
    dif_r  = 33'(rear_left_speed) - 33'(rear_right_speed);
  end

  logic               v1;
  logic               conn1;
  logic signed [31:0] tq1;
  logic signed [49:0] tprod1;
  logic signed [50:0] spf1, spr1;
  logic [32:0]        df1, dr1;
  logic               fsl1, rsl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    conn1  <= connected;
    tq1    <= shaft_torque;
    tprod1 <= 50'(shaft_torque) * 50'(ff_s);
    spf1   <= 51'(ff_s) * 51'(sum_f);
    spr1   <= 51'(fr_w) * 51'(sum_r);
    df1    <= dif_f < 0 ? 33'(-dif_f) : 33'(dif_f);
    dr1    <= dif_r < 0 ? 33'(-dif_r) : 33'(dif_r);
    // On equal magnitudes the right wheel counts as slower.
    fsl1   <= abs_fl < abs_fr;
    rsl1   <= abs_rl < abs_rr;
  end

  // Stage 2: axle shares, driveshaft speed, bias ratios.
  logic signed [33:0] tf_full;
  logic signed [34:0] tr_full;
  logic signed [51:0] spd_sum;
  logic signed [51:0] spd_q;

  always_comb begin
    tf_full = 34'((tprod1 + (tprod1 < 0 ? 50'sd65535 : 50'sd0)) >>> 16);
    tr_full = 35'(tq1) - 35'(tf_full);
    spd_sum = 52'(spf1) + 52'(spr1);
    spd_q   = (spd_sum + (spd_sum < 0 ? 52'sd131071 : 52'sd0)) >>> 17;
  end

  logic               v2;
  logic               conn2;
  logic signed [31:0] tf2, tr2, spd2;
  logic [BIAS_W-1:0]  bf2, br2;
  logic               fsl2, rsl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    conn2 <= conn1;
    tf2   <= sat32(52'(tf_full));
    tr2   <= sat32(52'(tr_full));
    spd2  <= sat32(spd_q);
    bf2   <= bias(front_max_bias, df1);
    br2   <= bias(rear_max_bias, dr1);
    fsl2  <= fsl1;
    rsl2  <= rsl1;
  end

  // Stage 3: divider operands on magnitudes; the sign is put back at the end.
  logic [WORD_W-1:0] mag_f, mag_r;
  assign mag_f = tf2 < 0 ? WORD_W'(-33'(tf2)) : WORD_W'(tf2);
  assign mag_r = tr2 < 0 ? WORD_W'(-33'(tr2)) : WORD_W'(tr2);

  logic             v3;
  logic [NUM_W-1:0] num_f3, num_r3;
  logic [DEN_W-1:0] den_f3, den_r3;
  side_t            side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    num_f3 <= NUM_W'(mag_f) * NUM_W'(bf2);
    num_r3 <= NUM_W'(mag_r) * NUM_W'(br2);
    den_f3 <= DEN_W'(1 << 24) + DEN_W'(bf2);
    den_r3 <= DEN_W'(1 << 24) + DEN_W'(br2);
    side3.conn            <= conn2;
    side3.front_t         <= tf2;
    side3.rear_t          <= tr2;
    side3.front_neg       <= tf2 < 0;
    side3.rear_neg        <= tr2 < 0;
    side3.front_slow_left <= fsl2;
    side3.rear_slow_left  <= rsl2;
    side3.speed           <= spd2;
  end

  // Slower-wheel torque magnitude of each axle.
  logic             vq_f, vq_r;
  logic [Q_W-1:0]   q_f, q_r;

  dts_axle_div u_div_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num_f3),
    .den       (den_f3),
    .out_valid (vq_f),
    .quot      (q_f)
  );

  dts_axle_div u_div_rear (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num_r3),
    .den       (den_r3),
    .out_valid (vq_r),
    .quot      (q_r)
  );

  // Hold the rest of each request in step with the dividers.
  side_t side_line [Q_W];

  always_ff @(posedge clk) begin
    side_line[0] <= side3;
    for (int i = 1; i < Q_W; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  side_t sd;
  assign sd = side_line[Q_W-1];

  // Output stage: restore signs, give the remainder to the faster wheel.
  logic signed [WORD_W:0] slow_f, slow_r, fast_f, fast_r;

  always_comb begin
    slow_f = sd.front_neg ? -$signed({1'b0, q_f}) : $signed({1'b0, q_f});
    slow_r = sd.rear_neg ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    fast_f = 33'(sd.front_t) - slow_f;
    fast_r = 33'(sd.rear_t) - slow_r;
  end

  logic signed [WORD_W-1:0] held_shaft_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      held_shaft_speed <= '0;
    end else begin
      done <= vq_f & vq_r;
      // Update the held speed only for requests taken while connected.
      if (vq_f && vq_r && sd.conn) begin
        held_shaft_speed <= sd.speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sd.conn) begin
      front_left_torque  <= sat32(52'(sd.front_slow_left ? slow_f : fast_f));
      front_right_torque <= sat32(52'(sd.front_slow_left ? fast_f : slow_f));
      rear_left_torque   <= sat32(52'(sd.rear_slow_left ? slow_r : fast_r));
      rear_right_torque  <= sat32(52'(sd.rear_slow_left ? fast_r : slow_r));
      driveshaft_speed   <= sd.speed;
    end else begin
      // Disconnected: drop the torques, repeat the last speed.
      front_left_torque  <= '0;
      front_right_torque <= '0;
      rear_left_torque   <= '0;
      rear_right_torque  <= '0;
      driveshaft_speed   <= held_shaft_speed;
    end
  end

endmodule

### hdl/dts_axle_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module dts_axle_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [dts_pkg::NUM_W-1:0] num,
  input  logic [dts_pkg::DEN_W-1:0] den,
  output logic                      out_valid,
  output logic [dts_pkg::Q_W-1:0]   quot
);
  import dts_pkg::*;

  logic             vld   [Q_W];
  logic [DEN_W-1:0] rem   [Q_W];
  logic [Q_W-1:0]   lo    [Q_W];
  logic [Q_W-1:0]   quo   [Q_W];
  logic [DEN_W-1:0] dd    [Q_W];

  logic             src_v   [Q_W];
  logic [DEN_W-1:0] src_rem [Q_W];
  logic [Q_W-1:0]   src_lo  [Q_W];
  logic [Q_W-1:0]   src_quo [Q_W];
  logic [DEN_W-1:0] src_dd  [Q_W];
  logic [DEN_W:0]   trial   [Q_W];
  logic             fits    [Q_W];
  logic [DEN_W-1:0] rem_next [Q_W];

  // The numerator is below den * 2^Q_W, so its top part starts below den.
  always_comb begin
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        src_v[i]   = in_valid;
        src_rem[i] = num[NUM_W-1:Q_W];
        src_lo[i]  = num[Q_W-1:0];
        src_quo[i] = '0;
        src_dd[i]  = den;
      end else begin
        src_v[i]   = vld[i-1];
        src_rem[i] = rem[i-1];
        src_lo[i]  = lo[i-1];
        src_quo[i] = quo[i-1];
        src_dd[i]  = dd[i-1];
      end
      trial[i] = {src_rem[i], src_lo[i][Q_W-1]};
      fits[i]  = trial[i] >= {1'b0, src_dd[i]};
      rem_next[i] = fits[i] ? DEN_W'(trial[i] - {1'b0, src_dd[i]}) : trial[i][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_W; i++) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= src_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_W; i++) begin
      rem[i] <= rem_next[i];
      lo[i]  <= {src_lo[i][Q_W-2:0], 1'b0};
      quo[i] <= {src_quo[i][Q_W-2:0], fits[i]};
      dd[i]  <= src_dd[i];
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = quo[Q_W-1];

endmodule

### tb/driveline_torque_split_tb.sv
// Self-checking testbench for the driveline torque split: directed, config-extreme, disconnect and random runs.
module driveline_torque_split_tb;
  import dts_pkg::*;

  localparam int PIPE_DEPTH = 4 + Q_W;   // registers from request to done
  localparam int STALL_LIMIT = 5000;     // idle cycles before the watchdog trips

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct {
    word_t fl_t;
    word_t fr_t;
    word_t rl_t;
    word_t rr_t;
    word_t spd;
  } spindle_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t shaft_torque = '0;
  word_t front_left_speed = '0;
  word_t front_right_speed = '0;
  word_t rear_left_speed = '0;
  word_t rear_right_speed = '0;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  word_t front_left_torque, front_right_torque, rear_left_torque, rear_right_torque;
  word_t driveshaft_speed;

  // Shadow copy of the block's registers and held speed.
  logic        conn_q;
  logic [16:0] fraction_q;
  logic [12:0] front_bias_q;
  logic [12:0] rear_bias_q;
  word_t       held_speed_q;

  spindle_out_t pending_torques[$];
  int mismatch_count = 0;
  int result_count = 0;
  int request_count = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  driveline_torque_split dut (.*);

  always #4 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Limited-slip split of one axle: the slower wheel takes bias/(1+bias) of the torque.
  task automatic split_axle(input longint t, input longint mb, input longint sl,
                            input longint sr, output longint tl, output longint tr);
    longint d, bias, slow;
    d = mag(sl - sr);
    if (d > 32768) bias = mb * 65536;
    else if (d > 16384) bias = (mb - 256) * 4 * d + (512 - mb) * 65536;
    else bias = 64'sd16777216;
    slow = (t * bias) / (64'sd16777216 + bias);
    if (mag(sl) < mag(sr)) begin
      tl = slow;
      tr = t - slow;
    end else begin
      tl = t - slow;
      tr = slow;
    end
  endtask

  task automatic predict_torques(input word_t tq, fl, fr, rl, rr);
    spindle_out_t e;
    longint ff, spd, tf, tr, a, b, c, f;
    if (!conn_q) begin
      e = '{0, 0, 0, 0, held_speed_q};
    end else begin
      ff = fraction_q;
      spd = (ff * (longint'(fl) + fr) + (65536 - ff) * (longint'(rl) + rr)) / 131072;
      held_speed_q = word_t'(clamp32(spd));
      tf = (longint'(tq) * ff) / 65536;
      tr = clamp32(tq - tf);
      tf = clamp32(tf);
      split_axle(tf, front_bias_q, fl, fr, a, b);
      split_axle(tr, rear_bias_q, rl, rr, c, f);
      e = '{word_t'(clamp32(a)), word_t'(clamp32(b)), word_t'(clamp32(c)),
            word_t'(clamp32(f)), held_speed_q};
    end
    pending_torques.push_back(e);
  endtask

  // Drive one request and hold start until it is taken; start stays high afterwards unless the idle gap drops it.
  task automatic send_request(input word_t tq, fl, fr, rl, rr);
    shaft_torque <= tq;
    front_left_speed <= fl;
    front_right_speed <= fr;
    rear_left_speed <= rl;
    rear_right_speed <= rr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_torques(tq, fl, fr, rl, rr);
    request_count++;
    idle_gap();
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return;
    n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 45);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start, let the pipeline empty, then settle before touching registers.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_torques.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CONNECTED:      conn_q = val[0];
      REG_FRONT_FRACTION: fraction_q = val[16:0];
      REG_FRONT_MAX_BIAS: front_bias_q = val[12:0];
      REG_REAR_MAX_BIAS:  rear_bias_q = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic c, input logic [16:0] ff,
                            input logic [12:0] fb, input logic [12:0] rb);
    write_reg(REG_CONNECTED, CFG_W'(c));
    write_reg(REG_FRONT_FRACTION, CFG_W'(ff));
    write_reg(REG_FRONT_MAX_BIAS, CFG_W'(fb));
    write_reg(REG_REAR_MAX_BIAS, CFG_W'(rb));
  endtask

  // Pick a wheel speed pair, steering the difference around the bias breakpoints.
  task automatic speed_pair(output word_t a, output word_t b);
    int sel;
    word_t diff;
    sel = $urandom_range(0, 9);
    a = (sel < 7) ? word_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000
                  : word_t'($urandom);
    case ($urandom_range(0, 8))
      0: diff = 0;
      1: diff = 16384;
      2: diff = 16385;
      3: diff = 32768;
      4: diff = 32769;
      5: diff = $urandom_range(0, 40000);
      6: diff = $urandom_range(16000, 33000);
      7: diff = $urandom_range(0, 32'h0040_0000);
      default: diff = $urandom;
    endcase
    if ($urandom_range(0, 1)) diff = -diff;
    b = (sel == 9) ? word_t'($urandom) : a + diff;
    if ($urandom_range(0, 1)) {a, b} = {b, a};
  endtask

  function automatic word_t rand_torque();
    case ($urandom_range(0, 4))
      0: return word_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return word_t'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  task automatic random_requests(input int n);
    word_t fl, fr, rl, rr;
    repeat (n) begin
      speed_pair(fl, fr);
      speed_pair(rl, rr);
      send_request(rand_torque(), fl, fr, rl, rr);
    end
  endtask

  // Field extremes, each bias region, equal-magnitude speeds, saturation.
  task automatic test_directed_defaults();
    send_request(0, 0, 0, 0, 0);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000,
                 -32'sh0001_0000, 32'sh0001_0000);
    send_request(32'sh0064_0000, 100000, 100000 + 16384, 100000, 100000 + 16385);
    send_request(32'sh0064_0000, 100000, 100000 + 32768, 100000 + 32769, 100000);
    send_request(-32'sh0064_0000, 200000, 200000 + 24000, 5, -5);
    send_request(32'sh7FFF_FFFF, 50000, 90000, -90000, 50000);
    send_request(-32'sh0000_0001, 1, 0, 0, 1);
    drain();
  endtask

  // Fraction and bias at and past their documented ends.
  task automatic test_config_extremes();
    set_config(1'b1, 17'd0, 13'd256, 13'd4096);
    random_requests(6);
    send_request(32'sh7FFF_FFFF, 0, 40000, 40000, 0);
    drain();
    set_config(1'b1, 17'd65536, 13'd4096, 13'd256);
    random_requests(6);
    send_request(32'sh8000_0000, 0, 40000, 40000, 0);
    drain();
    set_config(1'b1, 17'h1FFFF, 13'd0, 13'h1FFF);
    random_requests(8);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    send_request(32'sh8000_0000, 20000, 0, 0, 30000);
    drain();
  endtask

  // While disconnected the torques are zero and the last speed is held.
  task automatic test_disconnect();
    set_config(1'b1, 17'd40000, 13'd700, 13'd300);
    random_requests(4);
    drain();
    write_reg(REG_CONNECTED, CFG_W'(0));
    random_requests(8);
    drain();
    write_reg(REG_CONNECTED, CFG_W'(1));
    random_requests(4);
    drain();
  endtask

  // Random requests over a spread of settings, one stretch with no gaps.
  task automatic test_random_traffic();
    for (int p = 0; p < 12; p++) begin
      set_config(($urandom_range(0, 7) != 0),
                 (p % 4 == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                 (p % 5 == 0) ? 13'($urandom) : 13'($urandom_range(256, 4096)),
                 (p % 3 == 0) ? 13'($urandom) : 13'($urandom_range(256, 4096)));
      no_gaps = (p == 5);
      random_requests(100);
      no_gaps = 1'b0;
      drain();
    end
  endtask

  // Compare each result against the oldest prediction.
  always @(posedge clk) begin
    spindle_out_t e;
    if (!rst && done) begin
      result_count++;
      if (pending_torques.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: result with no request outstanding");
      end else begin
        e = pending_torques.pop_front();
        if (front_left_torque !== e.fl_t || front_right_torque !== e.fr_t ||
            rear_left_torque !== e.rl_t || rear_right_torque !== e.rr_t ||
            driveshaft_speed !== e.spd) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result %0d exp fl=%0d fr=%0d rl=%0d rr=%0d spd=%0d",
                     result_count, e.fl_t, e.fr_t, e.rl_t, e.rr_t, e.spd);
            $display("       got fl=%0d fr=%0d rl=%0d rr=%0d spd=%0d",
                     front_left_torque, front_right_torque, rear_left_torque,
                     rear_right_torque, driveshaft_speed);
          end
        end
      end
    end
  end

  // Watchdog: trip when nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    conn_q = 1'b1;
    fraction_q = 17'd32768;
    front_bias_q = 13'd512;
    rear_bias_q = 13'd512;
    held_speed_q = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_disconnect();
    test_random_traffic();
    drain();
    if (pending_torques.size() != 0) mismatch_count += pending_torques.size();
    $display("Covered %0d requests, %0d results, over fraction/bias extremes and disconnect",
             request_count, result_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
